FILE: src/pkq_pkg.sv
// ----------------------------------------------------------------------------
// pkq_pkg
// Shared types and codes of the policy keyed heap queue: sequencer states,
// order policy and operation codes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pkq_pkg;

    // fixed field widths of the channels
    localparam int PID_W      = 8;
    localparam int PRI_W      = 16;
    localparam int TIME_PORT_W = 16;
    localparam int COUNT_W    = 7;
    localparam int POLICY_W   = 2;
    localparam int STATUS_W   = 2;

    // order policy codes
    localparam logic [POLICY_W-1:0] POL_ARRIVAL   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_REMAINING = 2'd1;
    localparam logic [POLICY_W-1:0] POL_PRIORITY  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_PID       = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CH,
        ST_DN_CMP,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: src/pkq_if.sv
// ----------------------------------------------------------------------------
// pkq channel interfaces
// Input channel carries one heap operation, output channel one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pkq_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  entry_pid;
    logic [15:0] entry_arrival;
    logic [15:0] entry_remaining;
    logic [15:0] entry_priority;

    modport source (
        output valid, mode, entry_pid, entry_arrival, entry_remaining, entry_priority,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_pid, entry_arrival, entry_remaining, entry_priority,
        output ready
    );
endinterface

interface pkq_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  head_pid;
    logic [15:0] head_arrival;
    logic [15:0] head_remaining;
    logic [15:0] head_priority;
    logic [6:0]  entry_count;
    logic        root_moved;
    logic [1:0]  status;

    modport source (
        output valid, head_pid, head_arrival, head_remaining, head_priority,
               entry_count, root_moved, status,
        input  ready
    );
    modport sink (
        input  valid, head_pid, head_arrival, head_remaining, head_priority,
               entry_count, root_moved, status,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/policy_keyed_heap_queue_core.sv
// ----------------------------------------------------------------------------
// policy_keyed_heap_queue_core
// Binary min-heap of task entries ordered by a programmable policy.
//
// i_in carries one operation per beat: insert an entry (sift up) or overwrite
// the root entry (sift down). o_out returns one beat per operation with the
// root entry, entry count, moved flag and status. i_cfg_we / i_cfg_wdata set
// the order policy; write it only while the queue is idle.
// One operation is in flight at a time; i_in.ready is high only while idle.
// An insert per level reads and compares the parent, moving it down while
// the entry goes before it; an update per level reads both children, picks
// the one that goes first and moves it up while it goes before the entry.
// Each writes the entry where it lands. i_in.ready rises again as the result
// is loaded. An operation's length is set by the single order comparator,
// used once per level on the way up and twice per level on the way down, and
// by the registered read of the entry memory. Full insert and update on empty
// write no entry and go straight to the result step. Reset empties the queue
// and selects earliest arrival.
// A result waits in the output register while o_out.ready is low; the next
// operation is taken meanwhile and holds in its last step until it frees.
// ----------------------------------------------------------------------------
`default_nettype none

module policy_keyed_heap_queue_core
    import pkq_pkg::*;
#(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    pkq_in_if.sink                   i_in,
    pkq_out_if.source                o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [POLICY_W-1:0] i_cfg_wdata
);

    localparam int TB = (TIME_BITS < TIME_PORT_W) ? TIME_BITS : TIME_PORT_W;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [TB-1:0]    arrival;
        logic [TB-1:0]    remaining;
        logic [PRI_W-1:0] prio;
    } t_slot;

    // control and datapath registers
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [POLICY_W-1:0] r_policy;
    logic               r_mode, n_mode;
    logic [STATUS_W-1:0] r_status, n_status;
    t_slot              r_e, n_e;
    logic [AW-1:0]      r_pos, n_pos;
    t_slot              r_child, n_child;
    logic [AW-1:0]      r_cidx, n_cidx;
    t_slot              r_head;
    logic               r_out_valid;
    t_slot              r_out_head;
    logic [CW-1:0]      r_out_count;
    logic               r_out_moved;
    logic [STATUS_W-1:0] r_out_status;

    // entry memory
    t_slot              r_mem [HEAP_DEPTH];
    t_slot              r_rd0, r_rd1;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_slot              mem_wdata;
    logic [AW-1:0]      rd_addr0, rd_addr1;

    // compare unit operands
    t_slot              cmp_x, cmp_y;
    logic               cmp_before;

    // index arithmetic
    logic [XW-1:0]      left_x, right_x, count_x;
    logic [AW-1:0]      parent_idx;
    logic               count_full;
    logic               out_free;
    logic               in_beat;
    t_slot              in_slot;

    assign left_x     = XW'({r_pos, 1'b1});
    assign right_x    = left_x + XW'(1);
    assign count_x    = XW'(r_count);
    assign parent_idx = (r_pos - AW'(1)) >> 1;
    assign count_full = (r_count == CW'(HEAP_DEPTH));
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;

    assign in_slot.pid       = i_in.entry_pid;
    assign in_slot.arrival   = i_in.entry_arrival[TB-1:0];
    assign in_slot.remaining = i_in.entry_remaining[TB-1:0];
    assign in_slot.prio      = i_in.entry_priority;

    assign i_in.ready = (r_state == ST_IDLE);

    pkq_order_cmp #(
        .TIME_W (TB)
    ) u_cmp (
        .i_policy      (r_policy),
        .i_x_pid       (cmp_x.pid),
        .i_x_arrival   (cmp_x.arrival),
        .i_x_remaining (cmp_x.remaining),
        .i_x_priority  (cmp_x.prio),
        .i_y_pid       (cmp_y.pid),
        .i_y_arrival   (cmp_y.arrival),
        .i_y_remaining (cmp_y.remaining),
        .i_y_priority  (cmp_y.prio),
        .o_before      (cmp_before)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_in.mode == MODE_INSERT) begin
                        n_state = count_full ? ST_FIN : ST_UP_CHK;
                    end else begin
                        n_state = (r_count == '0) ? ST_FIN : ST_DN_RD;
                    end
                end
            end
            ST_UP_CHK: begin
                n_state = (r_pos == '0) ? ST_FIN : ST_UP_CMP;
            end
            ST_UP_CMP: begin
                n_state = cmp_before ? ST_UP_CHK : ST_FIN;
            end
            ST_DN_RD: begin
                n_state = (left_x >= count_x) ? ST_FIN : ST_DN_CH;
            end
            ST_DN_CH: begin
                n_state = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                n_state = cmp_before ? ST_DN_RD : ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath control per state
    always_comb begin
        n_count   = r_count;
        n_mode    = r_mode;
        n_status  = r_status;
        n_e       = r_e;
        n_pos     = r_pos;
        n_child   = r_child;
        n_cidx    = r_cidx;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_e;
        rd_addr0  = parent_idx;
        rd_addr1  = right_x[AW-1:0];
        cmp_x     = r_e;
        cmp_y     = r_rd0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_mode   = i_in.mode;
                    n_e      = in_slot;
                    n_status = STAT_OK;
                    if (i_in.mode == MODE_INSERT) begin
                        n_pos = r_count[AW-1:0];
                        if (count_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_pos = '0;
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end
                    end
                end
            end
            ST_UP_CHK: begin
                // read the parent, or land at the root
                rd_addr0 = parent_idx;
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end
            end
            ST_UP_CMP: begin
                // move the parent down while the new entry goes before it
                cmp_x = r_e;
                cmp_y = r_rd0;
                mem_we = 1'b1;
                if (cmp_before) begin
                    mem_wdata = r_rd0;
                    n_pos     = parent_idx;
                end
            end
            ST_DN_RD: begin
                // read both children, or land here when there are none
                rd_addr0 = left_x[AW-1:0];
                rd_addr1 = right_x[AW-1:0];
                if (left_x >= count_x) begin
                    mem_we = 1'b1;
                end
            end
            ST_DN_CH: begin
                // pick the child that goes first
                cmp_x = r_rd1;
                cmp_y = r_rd0;
                if ((right_x < count_x) && cmp_before) begin
                    n_child = r_rd1;
                    n_cidx  = right_x[AW-1:0];
                end else begin
                    n_child = r_rd0;
                    n_cidx  = left_x[AW-1:0];
                end
            end
            ST_DN_CMP: begin
                // move the child up while it goes before the entry
                cmp_x  = r_child;
                cmp_y  = r_e;
                mem_we = 1'b1;
                if (cmp_before) begin
                    mem_wdata = r_child;
                    n_pos     = r_cidx;
                end
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // entry memory with registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    // shadow copy of the root slot
    always_ff @(posedge i_clk) begin
        if (mem_we && (mem_waddr == '0)) begin
            r_head <= mem_wdata;
        end
    end

    // sequencer working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_e      <= n_e;
        r_pos    <= n_pos;
        r_child  <= n_child;
        r_cidx   <= n_cidx;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_policy <= POL_ARRIVAL;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_head   <= (r_count == '0) ? t_slot'('0) : r_head;
            r_out_count  <= r_count;
            r_out_moved  <= (r_mode == MODE_UPDATE) && (r_status == STAT_OK) &&
                            (r_pos != '0);
            r_out_status <= r_status;
        end
    end

    // result beat
    assign o_out.valid          = r_out_valid;
    assign o_out.head_pid       = r_out_head.pid;
    assign o_out.head_arrival   = TIME_PORT_W'(r_out_head.arrival);
    assign o_out.head_remaining = TIME_PORT_W'(r_out_head.remaining);
    assign o_out.head_priority  = r_out_head.prio;
    assign o_out.entry_count    = COUNT_W'(r_out_count);
    assign o_out.root_moved     = r_out_moved;
    assign o_out.status         = r_out_status;

endmodule

`default_nettype wire

FILE: src/pkq_order_cmp.sv
// ----------------------------------------------------------------------------
// pkq_order_cmp
// Shared order compare: tells whether entry x goes strictly before entry y
// under the selected policy, lower pid breaking ties.
// ----------------------------------------------------------------------------
`default_nettype none

module pkq_order_cmp
    import pkq_pkg::*;
#(
    parameter int TIME_W = 16
) (
    input  wire logic [POLICY_W-1:0] i_policy,
    input  wire logic [PID_W-1:0]    i_x_pid,
    input  wire logic [TIME_W-1:0]   i_x_arrival,
    input  wire logic [TIME_W-1:0]   i_x_remaining,
    input  wire logic [PRI_W-1:0]    i_x_priority,
    input  wire logic [PID_W-1:0]    i_y_pid,
    input  wire logic [TIME_W-1:0]   i_y_arrival,
    input  wire logic [TIME_W-1:0]   i_y_remaining,
    input  wire logic [PRI_W-1:0]    i_y_priority,
    output logic                     o_before
);

    localparam int KEY_W = (TIME_W > PRI_W) ? TIME_W : PRI_W;

    logic [KEY_W-1:0] key_x;
    logic [KEY_W-1:0] key_y;
    logic             pid_lt;
    logic             use_key;

    // primary key select, priority order is reversed
    always_comb begin
        key_x   = '0;
        key_y   = '0;
        use_key = 1'b1;
        unique case (i_policy)
            POL_ARRIVAL: begin
                key_x = KEY_W'(i_x_arrival);
                key_y = KEY_W'(i_y_arrival);
            end
            POL_REMAINING: begin
                key_x = KEY_W'(i_x_remaining);
                key_y = KEY_W'(i_y_remaining);
            end
            POL_PRIORITY: begin
                key_x = KEY_W'(i_y_priority);
                key_y = KEY_W'(i_x_priority);
            end
            default: begin
                use_key = 1'b0;
            end
        endcase
    end

    assign pid_lt = (i_x_pid < i_y_pid);

    // key decides unless equal, then pid
    assign o_before = (use_key && (key_x != key_y)) ? (key_x < key_y) : pid_lt;

endmodule

`default_nettype wire
